// ===== rtl/core/bse_pkg.sv =====
// Shared types, widths and helpers for the Burning Ship escape-time unit.
`default_nettype none

package bse_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_BITS_DEF = 11;
    localparam int ITER_BITS_DEF  = 16;

    // Register file widths
    localparam int STEP_W    = 40;   // unsigned Q0.40
    localparam int OFFS_W    = 48;   // signed Q8.40
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    // Iteration datapath widths
    localparam int Q_W       = 32;   // signed Q4.28 point c
    localparam int Z_W       = 31;   // |z| parts, always in [0, 2^31-1]
    localparam int PROD_W    = 2 * Z_W;
    localparam int SQ_SHIFT  = 28;   // Q8.56 -> Q4.28
    localparam int X_SHIFT   = 27;   // 2*a*b in Q4.28
    localparam int MAG_W     = PROD_W + 1;
    localparam int ESC_BIT   = 58;   // 4.0 in Q8.56
    localparam int SUM_W     = 37;   // z update before abs and clamp
    localparam int NUM_CELLS = 2;

    // Reset values of the register file
    localparam logic [STEP_W-1:0]        STEP_RST  = 40'd6282923587;
    localparam logic signed [OFFS_W-1:0] OFFS_RST  = 48'sd2199023255552;
    localparam logic [15:0]              MAXIT_RST = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_STEP = 3'd0,
        CFG_OFFSET_RE  = 3'd1,
        CFG_OFFSET_IM  = 3'd2,
        CFG_MAX_ITER   = 3'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_MAP  = 3'd1,
        S_CMAP = 3'd2,
        S_RUN  = 3'd3,
        S_DONE = 3'd4
    } t_state;

    // Point handed from one cell to the next
    typedef struct packed {
        logic           valid;
        logic [Z_W-1:0] z_re;
        logic [Z_W-1:0] z_im;
    } t_cell_pass;

    // Status a cell reports for the point it holds
    typedef struct packed {
        logic valid;
        logic done;
        logic esc;
    } t_cell_stat;

    // Absolute value, clamped to 2^31-1
    function automatic logic [Z_W-1:0] abs_sat(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] a;
        a = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
        if (|a[SUM_W-1:Z_W]) begin
            return {Z_W{1'b1}};
        end
        return a[Z_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bse_pix_if.sv =====
// Pixel input channel: valid/ready with the pixel coordinate.
`default_nettype none

interface bse_pix_if #(
    parameter int COORD_BITS = bse_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bse_res_if.sv =====
// Result channel: valid/ready with pixel echo, iteration count and escape flag.
`default_nettype none

interface bse_res_if #(
    parameter int COORD_BITS = bse_pkg::COORD_BITS_DEF,
    parameter int ITER_BITS  = bse_pkg::ITER_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [ITER_BITS-1:0]  iter_count;
    logic                  escaped;

    modport source (output valid, output out_x, output out_y, output iter_count,
                    output escaped, input ready);
    modport sink   (input valid, input out_x, input out_y, input iter_count,
                    input escaped, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bse_map.sv =====
// Pixel to plane mapping: c = coord * step - offset, rounded to Q4.28 and clamped.
`default_nettype none

module bse_map #(
    parameter int COORD_BITS = bse_pkg::COORD_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic [COORD_BITS-1:0]                i_px,
    input  wire logic [COORD_BITS-1:0]                i_py,
    input  wire logic [bse_pkg::STEP_W-1:0]           i_step,
    input  wire logic signed [bse_pkg::OFFS_W-1:0]    i_off_re,
    input  wire logic signed [bse_pkg::OFFS_W-1:0]    i_off_im,
    output logic signed [bse_pkg::Q_W-1:0]            o_c_re,
    output logic signed [bse_pkg::Q_W-1:0]            o_c_im
);

    localparam int P_W = COORD_BITS + bse_pkg::STEP_W;
    localparam int V_W = P_W + 2;
    localparam int R_W = V_W - 12;

    logic [P_W-1:0]                  r_prod_x;
    logic [P_W-1:0]                  r_prod_y;
    logic signed [bse_pkg::Q_W-1:0]  r_c_re;
    logic signed [bse_pkg::Q_W-1:0]  r_c_im;
    logic signed [bse_pkg::Q_W-1:0]  n_c_re;
    logic signed [bse_pkg::Q_W-1:0]  n_c_im;

    // Round half up from Q8.40 to Q4.28, then clamp to [-8, 8)
    function automatic logic signed [bse_pkg::Q_W-1:0] map_round(
        input logic [P_W-1:0]                prod,
        input logic signed [bse_pkg::OFFS_W-1:0] off
    );
        logic signed [V_W-1:0] v;
        logic signed [R_W-1:0] r;
        v = signed'(V_W'(prod)) - V_W'(off) + signed'(V_W'(2048));
        r = v[V_W-1:12];
        if ((&r[R_W-1:bse_pkg::Q_W-1]) || !(|r[R_W-1:bse_pkg::Q_W-1])) begin
            return r[bse_pkg::Q_W-1:0];
        end
        return r[R_W-1] ? {1'b1, {(bse_pkg::Q_W-1){1'b0}}}
                        : {1'b0, {(bse_pkg::Q_W-1){1'b1}}};
    endfunction

    always_ff @(posedge i_clk) begin
        r_prod_x <= P_W'(i_px) * P_W'(i_step);
        r_prod_y <= P_W'(i_py) * P_W'(i_step);
    end

    always_comb begin
        n_c_re = map_round(r_prod_x, i_off_re);
        n_c_im = map_round(r_prod_y, i_off_im);
    end

    always_ff @(posedge i_clk) begin
        r_c_re <= n_c_re;
        r_c_im <= n_c_im;
    end

    assign o_c_re = r_c_re;
    assign o_c_im = r_c_im;

endmodule

`default_nettype wire

// ===== rtl/core/bse_cell.sv =====
// One iteration cell: holds a point, tests escape and hands the next z onward.
`default_nettype none

module bse_cell #(
    parameter int ITER_BITS = bse_pkg::ITER_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bse_pkg::t_cell_pass             i_pass,
    input  wire logic [ITER_BITS-1:0]            i_count,
    input  wire logic signed [bse_pkg::Q_W-1:0]  i_c_re,
    input  wire logic signed [bse_pkg::Q_W-1:0]  i_c_im,
    input  wire logic [ITER_BITS-1:0]            i_limit,
    output bse_pkg::t_cell_pass                  o_pass,
    output logic [ITER_BITS-1:0]                 o_count,
    output logic [ITER_BITS-1:0]                 o_held_count,
    output bse_pkg::t_cell_stat                  o_stat
);

    bse_pkg::t_cell_pass                r_pass;
    logic [ITER_BITS-1:0]               r_count;
    logic [bse_pkg::PROD_W-1:0]         sq_re;
    logic [bse_pkg::PROD_W-1:0]         sq_im;
    logic [bse_pkg::PROD_W-1:0]         cross_prod;
    logic [bse_pkg::MAG_W-1:0]          mag;
    logic signed [bse_pkg::SUM_W-1:0]   nz_re;
    logic signed [bse_pkg::SUM_W-1:0]   nz_im;
    logic                               esc;
    logic                               done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass.valid <= 1'b0;
        end else begin
            r_pass <= i_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= i_count;
    end

    always_comb begin
        sq_re      = bse_pkg::PROD_W'(r_pass.z_re) * bse_pkg::PROD_W'(r_pass.z_re);
        sq_im      = bse_pkg::PROD_W'(r_pass.z_im) * bse_pkg::PROD_W'(r_pass.z_im);
        cross_prod = bse_pkg::PROD_W'(r_pass.z_re) * bse_pkg::PROD_W'(r_pass.z_im);

        // Escape test on the exact Q8.56 magnitude of the held z
        mag = bse_pkg::MAG_W'(sq_re) + bse_pkg::MAG_W'(sq_im);
        esc = |mag[bse_pkg::MAG_W-1:bse_pkg::ESC_BIT];

        // The start point (count zero) has made no pass yet
        done = r_pass.valid && (r_count != '0) && (esc || (r_count >= i_limit));

        nz_re = signed'(bse_pkg::SUM_W'(sq_re[bse_pkg::PROD_W-1:bse_pkg::SQ_SHIFT]))
              - signed'(bse_pkg::SUM_W'(sq_im[bse_pkg::PROD_W-1:bse_pkg::SQ_SHIFT]))
              + bse_pkg::SUM_W'(i_c_re);
        nz_im = signed'(bse_pkg::SUM_W'(cross_prod[bse_pkg::PROD_W-1:bse_pkg::X_SHIFT]))
              + bse_pkg::SUM_W'(i_c_im);

        // Drop the point from the ring once it retires
        o_pass.valid = r_pass.valid && !done;
        o_pass.z_re  = bse_pkg::abs_sat(nz_re);
        o_pass.z_im  = bse_pkg::abs_sat(nz_im);
        o_count      = r_count + ITER_BITS'(1);

        o_stat.valid = r_pass.valid;
        o_stat.done  = done;
        o_stat.esc   = esc;
    end

    assign o_held_count = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/burning_ship_escape_time_unit.sv =====
// A pixel beat is mapped to c (product register, then rounded c register), iterated around
//   the ring until it retires and captured; the next pixel is taken once the result moves to the output register.
// Throughput: one Burning Ship pass per clock as the point steps around a ring of
//   two iteration cells.
// A finished result waits in the output register while the next pixel runs.
// Reset (synchronous, active low) empties the ring and loads the default registers.
`default_nettype none

module burning_ship_escape_time_unit #(
    parameter int COORD_BITS = bse_pkg::COORD_BITS_DEF,
    parameter int ITER_BITS  = bse_pkg::ITER_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bse_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bse_pkg::CFG_W-1:0]          i_cfg_data,
    bse_pix_if.sink                                 i_pix,
    bse_res_if.source                               o_res
);

    localparam int N = bse_pkg::NUM_CELLS;

    // Register file
    logic [bse_pkg::STEP_W-1:0]         r_step;
    logic signed [bse_pkg::OFFS_W-1:0]  r_off_re;
    logic signed [bse_pkg::OFFS_W-1:0]  r_off_im;
    logic [ITER_BITS-1:0]               r_max_iter;

    // Control and item state
    bse_pkg::t_state                    r_state;
    bse_pkg::t_state                    n_state;
    logic [COORD_BITS-1:0]              r_px;
    logic [COORD_BITS-1:0]              r_py;
    logic [ITER_BITS-1:0]               r_res_count;
    logic                               r_res_esc;
    logic                               r_out_valid;
    logic                               n_out_valid;
    logic [COORD_BITS-1:0]              r_out_x;
    logic [COORD_BITS-1:0]              r_out_y;
    logic [ITER_BITS-1:0]               r_out_count;
    logic                               r_out_esc;

    logic signed [bse_pkg::Q_W-1:0]     c_re;
    logic signed [bse_pkg::Q_W-1:0]     c_im;
    logic                               pix_beat;
    logic                               start;
    logic                               out_free;
    logic                               load_out;

    // Ring wiring
    bse_pkg::t_cell_pass                w_cell_in    [N];
    logic [ITER_BITS-1:0]               w_cnt_in     [N];
    bse_pkg::t_cell_pass                w_cell_out   [N];
    logic [ITER_BITS-1:0]               w_cnt_out    [N];
    logic [ITER_BITS-1:0]               w_held_count [N];
    bse_pkg::t_cell_stat                w_stat       [N];
    logic [N-1:0]                       w_cell_valid;
    logic                               any_done;
    logic [ITER_BITS-1:0]               done_count;
    logic                               done_esc;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= bse_pkg::STEP_RST;
            r_off_re   <= bse_pkg::OFFS_RST;
            r_off_im   <= bse_pkg::OFFS_RST;
            r_max_iter <= bse_pkg::MAXIT_RST[ITER_BITS-1:0];
        end else if (i_cfg_we) begin
            unique case (bse_pkg::t_cfg_idx'(i_cfg_idx))
                bse_pkg::CFG_PIXEL_STEP: r_step     <= i_cfg_data[bse_pkg::STEP_W-1:0];
                bse_pkg::CFG_OFFSET_RE:  r_off_re   <= signed'(i_cfg_data[bse_pkg::OFFS_W-1:0]);
                bse_pkg::CFG_OFFSET_IM:  r_off_im   <= signed'(i_cfg_data[bse_pkg::OFFS_W-1:0]);
                bse_pkg::CFG_MAX_ITER:   r_max_iter <= i_cfg_data[ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- mapping ----------------
    bse_map #(
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .i_clk    (i_clk),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_step   (r_step),
        .i_off_re (r_off_re),
        .i_off_im (r_off_im),
        .o_c_re   (c_re),
        .o_c_im   (c_im)
    );

    // ---------------- iteration ring ----------------
    always_comb begin
        // Inject the start point z = 0 into the first cell, else close the ring
        if (start) begin
            w_cell_in[0].valid = 1'b1;
            w_cell_in[0].z_re  = '0;
            w_cell_in[0].z_im  = '0;
            w_cnt_in[0]        = '0;
        end else begin
            w_cell_in[0] = w_cell_out[N-1];
            w_cnt_in[0]  = w_cnt_out[N-1];
        end
        for (int g = 1; g < N; g++) begin
            w_cell_in[g] = w_cell_out[g-1];
            w_cnt_in[g]  = w_cnt_out[g-1];
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        bse_cell #(
            .ITER_BITS (ITER_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_pass       (w_cell_in[g]),
            .i_count      (w_cnt_in[g]),
            .i_c_re       (c_re),
            .i_c_im       (c_im),
            .i_limit      (r_max_iter),
            .o_pass       (w_cell_out[g]),
            .o_count      (w_cnt_out[g]),
            .o_held_count (w_held_count[g]),
            .o_stat       (w_stat[g])
        );
        assign w_cell_valid[g] = w_stat[g].valid;
    end

    // Only one cell holds the point, so an OR picks its status
    always_comb begin
        any_done   = 1'b0;
        done_count = '0;
        done_esc   = 1'b0;
        for (int i = 0; i < N; i++) begin
            any_done   = any_done | w_stat[i].done;
            done_count = done_count | (w_stat[i].done ? w_held_count[i] : '0);
            done_esc   = done_esc | (w_stat[i].done & w_stat[i].esc);
        end
    end

    // ---------------- control ----------------
    assign pix_beat = i_pix.valid && i_pix.ready;
    assign out_free = !r_out_valid || o_res.ready;

    always_comb begin
        n_state     = r_state;
        start       = 1'b0;
        load_out    = 1'b0;
        i_pix.ready = 1'b0;
        unique case (r_state)
            bse_pkg::S_IDLE: begin
                i_pix.ready = 1'b1;
                if (i_pix.valid) begin
                    n_state = bse_pkg::S_MAP;
                end
            end
            bse_pkg::S_MAP: begin
                n_state = bse_pkg::S_CMAP;
            end
            bse_pkg::S_CMAP: begin
                start   = 1'b1;
                n_state = bse_pkg::S_RUN;
            end
            bse_pkg::S_RUN: begin
                if (any_done) begin
                    n_state = bse_pkg::S_DONE;
                end
            end
            bse_pkg::S_DONE: begin
                // Hold the result until the output register frees up
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = bse_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bse_pkg::S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bse_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_beat) begin
            r_px <= i_pix.pixel_x;
            r_py <= i_pix.pixel_y;
        end
        if (r_state == bse_pkg::S_RUN && any_done) begin
            r_res_count <= done_count;
            r_res_esc   <= done_esc;
        end
        if (load_out) begin
            r_out_x     <= r_px;
            r_out_y     <= r_py;
            r_out_count <= r_res_count;
            r_out_esc   <= r_res_esc;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_x      = r_out_x;
    assign o_res.out_y      = r_out_y;
    assign o_res.iter_count = r_out_count;
    assign o_res.escaped    = r_out_esc;

    // ---------------- assertions ----------------
    a_single_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cell_valid))
        else $error("more than one cell holds a point");

    a_beat_maps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_beat |=> (r_state == bse_pkg::S_MAP))
        else $error("pixel beat did not start mapping");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        any_done |-> (r_state == bse_pkg::S_RUN))
        else $error("cell retired a point outside the run phase");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.iter_count != '0))
        else $error("result with zero iterations");

endmodule

`default_nettype wire

// ===== tb/burning_ship_escape_time_unit_test.sv =====
// Self-checking testbench for the Burning Ship escape-time unit: directed table, then random.
`timescale 1ns / 1ps

module burning_ship_escape_time_unit_test;

    localparam int          DRAIN_CYCLES = 8;
    localparam int          LIMIT_NS     = 40_000_000;
    localparam logic [2:0]  CFG_NO_REG   = 3'd5;   // decodes to no register
    localparam longint      Q_TOP        = 64'sd2147483647;
    localparam longint      Q_BOTTOM     = -64'sd2147483648;
    localparam longint      ONE_Q40      = 64'sd1 << 40;

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic [15:0] iters;
        logic        esc;
    } t_pix_result;

    typedef enum logic {
        ROW_PIXEL,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [47:0] data;
        logic [10:0] x;
        logic [10:0] y;
        bit          typed;
        logic [15:0] iters;
        logic        esc;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [bse_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bse_pkg::CFG_W-1:0]     i_cfg_data;

    bse_pix_if pix ();
    bse_res_if res ();

    burning_ship_escape_time_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .o_res      (res)
    );

    // Shadow copy of the register file
    logic [39:0]        step_q;
    logic signed [47:0] off_re_q;
    logic signed [47:0] off_im_q;
    logic [15:0]        max_iter_q;

    t_pix_result pending_results[$];
    t_stim_row   stim_rows[$];
    int          errors = 0;
    bit          quiet  = 1'b0;
    bit          src_high = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Map a pixel coordinate to Q4.28: round half up, saturate to [-8, 8)
    function automatic longint plane_coord(logic [10:0] coord, logic signed [47:0] off);
        longint v;
        v = longint'(coord) * longint'(step_q) - longint'(off);
        v = (v + 2048) >>> 12;
        if (v > Q_TOP) v = Q_TOP;
        if (v < Q_BOTTOM) v = Q_BOTTOM;
        return v;
    endfunction

    function automatic longint fold_clamp(longint v);
        if (v < 0) v = -v;
        if (v > Q_TOP) v = Q_TOP;
        return v;
    endfunction

    function automatic t_pix_result escape_time(logic [10:0] px, logic [10:0] py);
        longint            c_re, c_im, zr, zi, nr, ni;
        longint unsigned   sq_r, sq_i, cross_prod, mag;
        int unsigned       count;
        logic              esc;
        t_pix_result       r;
        c_re  = plane_coord(px, off_re_q);
        c_im  = plane_coord(py, off_im_q);
        zr    = 0;
        zi    = 0;
        count = 0;
        forever begin
            sq_r       = longint'(zr) * longint'(zr);
            sq_i       = longint'(zi) * longint'(zi);
            cross_prod = longint'(zr) * longint'(zi);
            nr    = longint'(sq_r >> 28) - longint'(sq_i >> 28) + c_re;
            ni    = longint'(cross_prod >> 27) + c_im;
            zr    = fold_clamp(nr);
            zi    = fold_clamp(ni);
            count++;
            mag   = longint'(zr) * longint'(zr) + longint'(zi) * longint'(zi);
            esc   = (mag >= (64'd4 << 56));
            if (esc || count >= max_iter_q) break;
        end
        r.x     = px;
        r.y     = py;
        r.iters = count[15:0];
        r.esc   = esc;
        return r;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            bse_pkg::CFG_PIXEL_STEP: step_q     = data[39:0];
            bse_pkg::CFG_OFFSET_RE:  off_re_q   = data;
            bse_pkg::CFG_OFFSET_IM:  off_im_q   = data;
            bse_pkg::CFG_MAX_ITER:   max_iter_q = data[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Leave valid high after the beat so back-to-back pixels need no second assignment
    task automatic drive_pixel(input logic [10:0] x, input logic [10:0] y, input bit typed,
                               input t_pix_result known);
        int gap;
        gap = pick_gap();
        if (gap > 0 && src_high) begin
            pix.valid <= 1'b0;
            src_high = 1'b0;
        end
        repeat (gap) @(posedge i_clk);
        pix.valid   <= 1'b1;
        pix.pixel_x <= x;
        pix.pixel_y <= y;
        src_high = 1'b1;
        do @(posedge i_clk); while (!pix.ready);
        pending_results.push_back(typed ? known : escape_time(x, y));
    endtask

    task automatic park_source();
        if (src_high) begin
            pix.valid <= 1'b0;
            src_high = 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_write(input logic [2:0] idx, input logic [47:0] data);
        t_stim_row row;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        row.typed = 1'b0;
        stim_rows.push_back(row);
    endtask

    task automatic add_pixel(input logic [10:0] x, input logic [10:0] y, input bit typed,
                             input logic [15:0] iters, input logic esc);
        t_stim_row row;
        row.kind  = ROW_PIXEL;
        row.x     = x;
        row.y     = y;
        row.typed = typed;
        row.iters = iters;
        row.esc   = esc;
        stim_rows.push_back(row);
    endtask

    // Random window over the interesting part of the plane
    task automatic write_window(input logic [15:0] limit);
        logic [39:0] step;
        longint      center_re, center_im;
        step = (40'h80_0000_0000 >> (8 + $urandom_range(0, 10))) + 40'($urandom_range(0, 4095));
        center_re = longint'($urandom_range(0, 2400)) * ONE_Q40 / 1000 - ONE_Q40 * 18 / 10;
        center_im = longint'($urandom_range(0, 2400)) * ONE_Q40 / 1000 - ONE_Q40 * 12 / 10;
        cfg_write(bse_pkg::CFG_PIXEL_STEP, {8'($urandom), step});
        cfg_write(bse_pkg::CFG_OFFSET_RE, 48'(longint'(step) * 1024 - center_re));
        cfg_write(bse_pkg::CFG_OFFSET_IM, 48'(longint'(step) * 1024 - center_im));
        cfg_write(bse_pkg::CFG_MAX_ITER, {32'($urandom), limit});
    endtask

    // Result side: random stalls on ready, compare every beat against the oldest expectation
    initial begin : result_sink
        t_pix_result want;
        int          stall_left;
        stall_left = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res.valid && res.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing pending: x=%0d y=%0d",
                           res.out_x, res.out_y);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (res.out_x !== want.x) begin
                        $error("out_x: expected %0d, got %0d", want.x, res.out_x);
                        errors++;
                    end
                    if (res.out_y !== want.y) begin
                        $error("out_y: expected %0d, got %0d", want.y, res.out_y);
                        errors++;
                    end
                    if (res.iter_count !== want.iters) begin
                        $error("iter_count: expected %0d, got %0d", want.iters, res.iter_count);
                        errors++;
                    end
                    if (res.escaped !== want.esc) begin
                        $error("escaped: expected %0d, got %0d", want.esc, res.escaped);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = pick_gap();
                res.ready <= (stall_left == 0);
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_pix_result known;
        int          n_items;
        logic [15:0] limit;
        logic [39:0] step;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= bse_pkg::CFG_PIXEL_STEP;
        i_cfg_data  <= '0;
        pix.valid   <= 1'b0;
        pix.pixel_x <= '0;
        pix.pixel_y <= '0;
        step_q     = bse_pkg::STEP_RST;
        off_re_q   = bse_pkg::OFFS_RST;
        off_im_q   = bse_pkg::OFFS_RST;
        max_iter_q = bse_pkg::MAXIT_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window: (0,0) sits at -2-2i, (350,350) lands exactly on zero
        add_pixel(11'd0,    11'd0,    1, 16'd1,  1'b1);
        add_pixel(11'd2047, 11'd2047, 1, 16'd1,  1'b1);
        add_pixel(11'd350,  11'd350,  1, 16'd50, 1'b0);
        add_pixel(11'd2047, 11'd0,    0, 16'd0,  1'b0);
        add_pixel(11'd0,    11'd2047, 0, 16'd0,  1'b0);
        add_pixel(11'h555,  11'h2AA,  0, 16'd0,  1'b0);
        add_pixel(11'd300,  11'd340,  0, 16'd0,  1'b0);
        // A limit of zero or one still makes one pass
        add_write(bse_pkg::CFG_MAX_ITER, 48'd0);
        add_pixel(11'd350,  11'd350,  1, 16'd1,  1'b0);
        add_write(bse_pkg::CFG_MAX_ITER, 48'd1);
        add_pixel(11'd350,  11'd350,  1, 16'd1,  1'b0);
        // Escape on the pass that also hits the limit
        add_pixel(11'd0,    11'd0,    1, 16'd1,  1'b1);
        // Write to an index with no register behind it
        add_write(CFG_NO_REG, 48'hFFFF_FFFF_FFFF);
        add_pixel(11'd350,  11'd350,  1, 16'd1,  1'b0);
        // Upper data bits beyond the limit width are dropped
        add_write(bse_pkg::CFG_MAX_ITER, 48'hABCD_0000_0003);
        add_pixel(11'd350,  11'd350,  1, 16'd3,  1'b0);
        add_write(bse_pkg::CFG_PIXEL_STEP, 48'hFF00_0000_0000);
        add_write(bse_pkg::CFG_OFFSET_RE, 48'd0);
        add_write(bse_pkg::CFG_OFFSET_IM, 48'd0);
        add_pixel(11'd2047, 11'd2047, 1, 16'd3,  1'b0);
        add_pixel(11'h2AA,  11'h555,  1, 16'd3,  1'b0);
        // Offset extremes push c into saturation
        add_write(bse_pkg::CFG_OFFSET_RE, 48'h7FFF_FFFF_FFFF);
        add_pixel(11'd0,    11'd0,    1, 16'd1,  1'b1);
        add_write(bse_pkg::CFG_OFFSET_RE, 48'h8000_0000_0000);
        add_pixel(11'd5,    11'd9,    1, 16'd1,  1'b1);
        add_write(bse_pkg::CFG_PIXEL_STEP, 48'h00FF_FFFF_FFFF);
        add_write(bse_pkg::CFG_OFFSET_RE, 48'(bse_pkg::OFFS_RST));
        add_write(bse_pkg::CFG_OFFSET_IM, 48'(bse_pkg::OFFS_RST));
        add_write(bse_pkg::CFG_MAX_ITER, 48'd50);
        add_pixel(11'd1,    11'd1,    0, 16'd0,  1'b0);
        add_pixel(11'd2,    11'd2,    0, 16'd0,  1'b0);
        add_pixel(11'd682,  11'd1365, 0, 16'd0,  1'b0);
        add_write(bse_pkg::CFG_PIXEL_STEP, 48'(bse_pkg::STEP_RST));
        add_pixel(11'd200,  11'd120,  0, 16'd0,  1'b0);
        add_pixel(11'd260,  11'd260,  0, 16'd0,  1'b0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                park_source();
                wait_drained();
                cfg_write(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                known.x     = stim_rows[i].x;
                known.y     = stim_rows[i].y;
                known.iters = stim_rows[i].iters;
                known.esc   = stim_rows[i].esc;
                drive_pixel(stim_rows[i].x, stim_rows[i].y, stim_rows[i].typed, known);
            end
        end

        for (int phase = 0; phase < 10; phase++) begin
            park_source();
            wait_drained();
            quiet = (phase % 4 == 3);
            if (phase == 2 || phase == 6) begin
                // Wild settings across the whole register range
                case ($urandom_range(0, 2))
                    0: step = '1;
                    1: step = '0;
                    default: step = {8'($urandom), 32'($urandom)};
                endcase
                cfg_write(bse_pkg::CFG_PIXEL_STEP, {8'($urandom), step});
                cfg_write(bse_pkg::CFG_OFFSET_RE, {16'($urandom), 32'($urandom)});
                cfg_write(bse_pkg::CFG_OFFSET_IM, {16'($urandom), 32'($urandom)});
                cfg_write(bse_pkg::CFG_MAX_ITER, {32'($urandom), 16'($urandom_range(1, 300))});
                n_items = 60;
            end else if (phase == 4) begin
                // Full-depth limit: keep it to a handful of pixels
                write_window(16'hFFFF);
                n_items = 3;
            end else begin
                limit = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(65, 255))
                                                     : 16'($urandom_range(1, 64));
                write_window(limit);
                n_items = 130;
            end
            for (int k = 0; k < n_items; k++) begin
                drive_pixel(11'($urandom), 11'($urandom), 0, known);
            end
        end

        park_source();
        wait_drained();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
